@@ rtl/core/srrt_pkg.sv @@
// Shared types, constants and control structs of the selective-repeat receive tracker.
package srrt_pkg;

	localparam int MAX_CHUNKS       = 4096;
	localparam int MAP_AW           = $clog2(MAX_CHUNKS);
	localparam int TOT_W            = MAP_AW + 1;
	localparam int NACK_BATCH       = 6;
	localparam int LIST_AW          = $clog2(NACK_BATCH);
	localparam int CNT_W            = $clog2(NACK_BATCH + 1);
	localparam int HEADER_BYTES     = 12;
	localparam int MIN_PACKET_BYTES = 4;
	localparam int BATCH_LIMIT      = 10;
	localparam int BATCH_W          = $clog2(BATCH_LIMIT);
	localparam int BIT_W            = $clog2(MAP_AW);

	localparam logic [15:0] FRAME_BYTES_RST = 16'd1024;
	localparam logic [12:0] CHUNK_TOTAL_RST = 13'd1;

	// Packet kinds.
	localparam logic [1:0] OP_CHUNK = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS   = 2'd0;
	localparam logic [1:0] KIND_MISSING  = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;

	// Chunk status codes.
	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_SHORT   = 3'd2;
	localparam logic [2:0] ST_BAD_LEN = 3'd3;
	localparam logic [2:0] ST_RANGE   = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;

	// Configuration register indexes.
	typedef enum logic {
		REG_FRAME_BYTES = 1'b0,
		REG_CHUNK_TOTAL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] packet_length;
		logic [31:0] sequence_number;
		logic [31:0] payload_length;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  status_code;
		logic [27:0] write_offset;
		logic [11:0] missing_index;
		logic        batch_end;
		logic        run_last;
	} result_t;

	typedef enum logic [1:0] {
		PATH_STATIC,
		PATH_LOOKUP,
		PATH_CHECK
	} path_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic latch;
		logic emit_static;
		logic rd_seq;
		logic emit_chunk;
		logic mod_init;
		logic mod_step;
		logic batch_init;
		logic scan_eval;
		logic emit_done;
		logic emit_entry;
		logic batch_next;
		logic commit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  clr_last;
		path_t path;
		logic  mod_last;
		logic  scan_end;
		logic  batch_empty;
		logic  entry_last;
		logic  last_batch;
	} sts_t;

endpackage

@@ rtl/core/selective_repeat_receive_tracker_core.sv @@
// Top level of the selective-repeat receive tracker: controller, datapath and config port.
// A rejected packet gives its one result beat after the decode state, a header that reaches
// the map lookup after the lookup state, and a new item can follow at once. A check request
// has a decode state and a bit-serial remainder step, then per batch a setup state, per map
// position scanned a registered read of the one-bit map and an evaluate state, an end state
// and then one beat out per cycle. After reset busy stays high through a map clearing pass;
// configuration writes are taken during that pass. The receiver cannot stall result beats.
module selective_repeat_receive_tracker_core import srrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       cmd,
	output logic        result_valid,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// The controller sequences the work of one item and tells the datapath what to do
	// each cycle; the datapath reports back what it has found.
	ctl_t ctl;
	sts_t sts;

	// Registers are plain flops that may be written in any cycle, so the configuration
	// channel is always ready. Writes are expected only while the block is idle.
	assign cfg_ready = 1'b1;

	srrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// The datapath holds the chunk map in a RAM, the scan pointer, the done flag, the
	// header checks, the bit-serial remainder unit for the scan start and the result
	// register that drives the result beat.
	srrt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (cmd),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ rtl/core/srrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/srrt_ctrl.sv @@
// Controller state machine of the receive tracker.
module srrt_ctrl import srrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_LOOKUP,
		S_MOD,
		S_BATCH_INIT,
		S_SCAN_RD,
		S_SCAN_EV,
		S_BATCH_DONE,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.path)
					PATH_LOOKUP: begin
						ctl.rd_seq = 1'b1;
						state_d    = S_LOOKUP;
					end
					PATH_CHECK: begin
						ctl.mod_init = 1'b1;
						state_d      = S_MOD;
					end
					default: begin
						ctl.emit_static = 1'b1;
						state_d         = S_IDLE;
					end
				endcase
			end
			S_LOOKUP: begin
				ctl.emit_chunk = 1'b1;
				state_d        = S_IDLE;
			end
			S_MOD: begin
				ctl.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_BATCH_INIT;
				end
			end
			S_BATCH_INIT: begin
				ctl.batch_init = 1'b1;
				state_d        = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				ctl.scan_eval = 1'b1;
				state_d       = sts.scan_end ? S_BATCH_DONE : S_SCAN_RD;
			end
			S_BATCH_DONE: begin
				if (sts.batch_empty) begin
					ctl.emit_done = 1'b1;
					ctl.commit    = 1'b1;
					state_d       = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				ctl.emit_entry = 1'b1;
				if (sts.entry_last) begin
					if (sts.last_batch) begin
						ctl.commit = 1'b1;
						state_d    = S_IDLE;
					end else begin
						ctl.batch_next = 1'b1;
						state_d        = S_BATCH_INIT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ rtl/core/srrt_dp.sv @@
// Datapath of the receive tracker: chunk map, header checks, remainder unit and scan.
module srrt_dp import srrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output result_t     result
);

	// Configuration.
	logic [15:0]      frame_q;
	logic [12:0]      total_q;
	logic [TOT_W-1:0] tot;

	// Latched item.
	logic [1:0]  op_q;
	logic [15:0] plen_q;
	logic [31:0] seq_q;
	logic [31:0] dlen_q;

	// Persistent state.
	logic              done_q;
	logic [MAP_AW-1:0] scan_q;
	logic [MAP_AW-1:0] clr_q;

	// Scan state.
	logic [MAP_AW-1:0]  ptr_q;
	logic [MAP_AW-1:0]  ptr0_q;
	logic [MAP_AW-1:0]  idx_q;
	logic [MAP_AW-1:0]  k_q;
	logic [BIT_W-1:0]   mbit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   e_q;
	logic [BATCH_W-1:0] batch_q;
	logic [MAP_AW-1:0]  list_q [NACK_BATCH];

	result_t res_q;
	result_t res_d;
	logic    res_valid_q;
	logic    emit;

	// Memory ports.
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr;
	logic              map_wdata;
	logic [MAP_AW-1:0] map_raddr;
	logic              map_rdata;

	// Decode.
	path_t       path;
	logic [1:0]  s_kind;
	logic [2:0]  s_status;
	logic [32:0] need_len;

	logic [TOT_W-1:0]  rem_shift;
	logic [TOT_W-1:0]  rem_next;
	logic [TOT_W-1:0]  idx_inc;
	logic [MAP_AW-1:0] idx_next;
	logic [TOT_W-1:0]  tot_m1;
	logic [MAP_AW-1:0] stop;
	logic              hit;
	logic              found_end;
	logic              entry_last;
	logic              last_batch;
	logic [27:0]       prod;

	always_comb begin
		if (total_q == 13'd0) begin
			tot = TOT_W'(1);
		end else if (total_q > 13'(MAX_CHUNKS)) begin
			tot = TOT_W'(MAX_CHUNKS);
		end else begin
			tot = total_q[TOT_W-1:0];
		end
	end

	assign need_len = 33'(HEADER_BYTES) + {1'b0, dlen_q};

	always_comb begin
		path     = PATH_STATIC;
		s_kind   = KIND_STATUS;
		s_status = ST_IGNORED;
		if (done_q) begin
			if (op_q == OP_CHECK) begin
				s_kind   = KIND_COMPLETE;
				s_status = '0;
			end
		end else if (plen_q < 16'(MIN_PACKET_BYTES)) begin
			s_status = ST_SHORT;
		end else if (op_q == OP_CHECK) begin
			path = PATH_CHECK;
		end else if (op_q == OP_CHUNK) begin
			if (plen_q < 16'(HEADER_BYTES)) begin
				s_status = ST_SHORT;
			end else if (dlen_q > {16'b0, frame_q} || {17'b0, plen_q} < need_len) begin
				s_status = ST_BAD_LEN;
			end else if (seq_q >= {{(32-TOT_W){1'b0}}, tot}) begin
				s_status = ST_RANGE;
			end else begin
				path = PATH_LOOKUP;
			end
		end
	end

	// One restoring step of scan_q modulo the chunk count.
	assign rem_shift = {ptr_q, scan_q[mbit_q]};
	assign rem_next  = (rem_shift >= tot) ? rem_shift - tot : rem_shift;

	assign idx_inc  = {1'b0, idx_q} + TOT_W'(1);
	assign idx_next = (idx_inc == tot) ? '0 : idx_inc[MAP_AW-1:0];
	assign tot_m1   = tot - TOT_W'(1);
	assign stop     = (ptr0_q == '0) ? tot_m1[MAP_AW-1:0] : ptr0_q - MAP_AW'(1);

	assign hit        = !map_rdata;
	assign found_end  = hit && (cnt_q == CNT_W'(NACK_BATCH - 1) || idx_q == stop);
	assign entry_last = (e_q == cnt_q - CNT_W'(1));
	assign last_batch = (batch_q == BATCH_W'(BATCH_LIMIT - 1)) || (ptr_q == ptr0_q);

	assign prod = 28'(seq_q[MAP_AW-1:0]) * 28'(frame_q);

	assign map_we    = ctl.clr_step || (ctl.emit_chunk && !map_rdata);
	assign map_waddr = ctl.clr_step ? clr_q : seq_q[MAP_AW-1:0];
	assign map_wdata = !ctl.clr_step;
	assign map_raddr = ctl.rd_seq ? seq_q[MAP_AW-1:0] : idx_q;

	srrt_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CHUNKS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	assign emit = ctl.emit_static || ctl.emit_chunk || ctl.emit_done || ctl.emit_entry;

	// Next result beat, built whole so the result register takes one write per cycle.
	always_comb begin
		res_d          = '0;
		res_d.run_last = 1'b1;
		if (ctl.emit_static) begin
			res_d.result_kind = s_kind;
			res_d.status_code = s_status;
		end else if (ctl.emit_chunk) begin
			res_d.result_kind  = KIND_STATUS;
			res_d.status_code  = map_rdata ? ST_DUP : ST_NEW;
			res_d.write_offset = map_rdata ? 28'd0 : prod;
		end else if (ctl.emit_done) begin
			res_d.result_kind = KIND_COMPLETE;
		end else if (ctl.emit_entry) begin
			res_d.result_kind   = KIND_MISSING;
			res_d.missing_index = list_q[e_q[LIST_AW-1:0]];
			res_d.batch_end     = entry_last;
			res_d.run_last      = entry_last && last_batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= FRAME_BYTES_RST;
			total_q     <= CHUNK_TOTAL_RST;
			done_q      <= 1'b0;
			scan_q      <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FRAME_BYTES: frame_q <= cfg_data;
					REG_CHUNK_TOTAL: total_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (ctl.clr_step) begin
				clr_q <= clr_q + MAP_AW'(1);
			end
			if (ctl.emit_done) begin
				done_q <= 1'b1;
			end
			if (ctl.commit) begin
				scan_q <= ptr_q;
			end
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q   <= item.opcode;
			plen_q <= item.packet_length;
			seq_q  <= item.sequence_number;
			dlen_q <= item.payload_length;
		end
		if (ctl.mod_init) begin
			ptr_q   <= '0;
			mbit_q  <= BIT_W'(MAP_AW - 1);
			batch_q <= '0;
		end
		if (ctl.mod_step) begin
			ptr_q  <= rem_next[MAP_AW-1:0];
			mbit_q <= mbit_q - BIT_W'(1);
			if (mbit_q == '0) begin
				ptr0_q <= rem_next[MAP_AW-1:0];
			end
		end
		if (ctl.batch_init) begin
			cnt_q <= '0;
			e_q   <= '0;
			k_q   <= '0;
			idx_q <= ptr_q;
		end
		if (ctl.scan_eval) begin
			if (hit) begin
				list_q[cnt_q[LIST_AW-1:0]] <= idx_q;
				cnt_q                      <= cnt_q + CNT_W'(1);
			end
			if (found_end) begin
				ptr_q <= idx_next;
			end else begin
				k_q   <= k_q + MAP_AW'(1);
				idx_q <= idx_next;
			end
		end
		if (ctl.emit_entry) begin
			e_q <= e_q + CNT_W'(1);
		end
		if (ctl.batch_next) begin
			batch_q <= batch_q + BATCH_W'(1);
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		sts             = '0;
		sts.clr_last    = (clr_q == {MAP_AW{1'b1}});
		sts.path        = path;
		sts.mod_last    = (mbit_q == '0);
		sts.scan_end    = found_end || ({1'b0, k_q} == tot_m1);
		sts.batch_empty = (cnt_q == '0);
		sts.entry_last  = entry_last;
		sts.last_batch  = last_batch;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ rtl/core/srrt_checker.sv @@
// Port-level assertions of the receive tracker and their bind to the top level.
module srrt_checker import srrt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	// An accepted item keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted item");

	// Result beats come only out of work that was under way.
	a_beat_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat without work in progress");

	// The last beat of an item is not followed at once by another beat.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.run_last) |=> !result_valid)
		else $error("result beat right after the last beat of an item");

	// Missing-chunk entries of one batch come in consecutive cycles.
	a_batch_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind == KIND_MISSING && !result.batch_end)
		|=> result_valid)
		else $error("gap inside a batch of missing-chunk entries");

endmodule

bind selective_repeat_receive_tracker_core srrt_checker u_srrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

@@ sim/receive_tracker_checker.sv @@
// Checker that predicts the tracker's result beats and compares them with the block's output.
module receive_tracker_checker import srrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       cmd,
	input  logic        result_valid,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int unsigned failures,
	output int unsigned outstanding,
	output int unsigned beats_checked,
	output int unsigned nack_entries,
	output int unsigned completions
);

	// Shadow copy of the tracker state and its two registers.
	bit          rx_map [MAX_CHUNKS];
	int unsigned scan_ptr;
	bit          done_flag;
	logic [15:0] frame_bytes;
	logic [12:0] chunk_total;

	result_t     pending_beats [$];
	int unsigned fail_cnt;
	int unsigned beat_cnt;
	int unsigned entry_cnt;
	int unsigned done_cnt;

	function automatic int unsigned chunk_count();
		if (chunk_total == 13'd0)
			return 1;
		if (chunk_total > 13'(MAX_CHUNKS))
			return MAX_CHUNKS;
		return 32'(chunk_total);
	endfunction

	function automatic result_t make_beat(input logic [1:0] kind, input logic [2:0] status,
		input logic [27:0] offset, input logic [11:0] index, input logic bend);
		result_t r;
		r.result_kind   = kind;
		r.status_code   = status;
		r.write_offset  = offset;
		r.missing_index = index;
		r.batch_end     = bend;
		r.run_last      = 1'b0;
		return r;
	endfunction

	// Circular walk of the map that yields up to ten NACK batches.
	task automatic nack_scan();
		int unsigned tot;
		int unsigned ptr;
		int unsigned stop;
		int unsigned cnt;
		int unsigned idx;
		int unsigned k;
		int unsigned miss [NACK_BATCH];
		tot  = chunk_count();
		ptr  = scan_ptr % tot;
		stop = (ptr + tot - 1) % tot;
		for (int b = 0; b < BATCH_LIMIT; b++) begin
			cnt = 0;
			for (k = 0; k < tot; k++) begin
				idx = (ptr + k) % tot;
				if (!rx_map[idx]) begin
					miss[cnt] = idx;
					cnt++;
					if (cnt == NACK_BATCH || idx == stop) begin
						ptr = (idx + 1) % tot;
						break;
					end
				end
			end
			if (cnt == 0) begin
				done_flag = 1'b1;
				pending_beats.push_back(make_beat(KIND_COMPLETE, ST_NEW, '0, '0, 1'b0));
				break;
			end
			for (int e = 0; e < cnt; e++)
				pending_beats.push_back(make_beat(KIND_MISSING, ST_NEW, '0, 12'(miss[e]),
					(e + 1) == cnt));
			if ((stop + 1) % tot == ptr)
				break;
		end
		scan_ptr = ptr;
	endtask

	task automatic track_packet(input item_t it);
		logic [2:0]      status;
		logic [27:0]     offset;
		longint unsigned need;
		longint unsigned prod;
		result_t         r;
		if (done_flag) begin
			if (it.opcode == OP_CHECK)
				pending_beats.push_back(make_beat(KIND_COMPLETE, ST_NEW, '0, '0, 1'b0));
			else
				pending_beats.push_back(make_beat(KIND_STATUS, ST_IGNORED, '0, '0, 1'b0));
		end else if (it.packet_length < 16'(MIN_PACKET_BYTES)) begin
			pending_beats.push_back(make_beat(KIND_STATUS, ST_SHORT, '0, '0, 1'b0));
		end else if (it.opcode == OP_CHECK) begin
			nack_scan();
		end else begin
			status = ST_IGNORED;
			offset = '0;
			if (it.opcode == OP_CHUNK) begin
				need = longint'(HEADER_BYTES) + longint'(it.payload_length);
				if (it.packet_length < 16'(HEADER_BYTES)) begin
					status = ST_SHORT;
				end else if (it.payload_length > 32'(frame_bytes) ||
					64'(it.packet_length) < need) begin
					status = ST_BAD_LEN;
				end else if (it.sequence_number >= chunk_count()) begin
					status = ST_RANGE;
				end else if (rx_map[it.sequence_number[11:0]]) begin
					status = ST_DUP;
				end else begin
					rx_map[it.sequence_number[11:0]] = 1'b1;
					status = ST_NEW;
					prod   = longint'(it.sequence_number) * longint'(frame_bytes);
					offset = prod[27:0];
				end
			end
			pending_beats.push_back(make_beat(KIND_STATUS, status, offset, '0, 1'b0));
		end
		// The last beat of every packet carries the end-of-run mark.
		r = pending_beats.pop_back();
		r.run_last = 1'b1;
		pending_beats.push_back(r);
	endtask

	function automatic bit field_differs(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want === got)
			return 1'b0;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		bit      bad;
		if (!arst_n) begin
			foreach (rx_map[i])
				rx_map[i] = 1'b0;
			scan_ptr    = 0;
			done_flag   = 1'b0;
			frame_bytes = FRAME_BYTES_RST;
			chunk_total = CHUNK_TOTAL_RST;
		end else begin
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_BYTES: frame_bytes = cfg_data;
					REG_CHUNK_TOTAL: chunk_total = cfg_data[12:0];
					default: ;
				endcase
			end
			// Compare first: a beat on this edge always belongs to an earlier packet.
			if (result_valid === 1'b1) begin
				if (pending_beats.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h", $time, result);
					fail_cnt++;
				end else begin
					want = pending_beats.pop_front();
					bad  = 1'b0;
					bad |= field_differs("result_kind", 64'(want.result_kind),
						64'(result.result_kind));
					bad |= field_differs("status_code", 64'(want.status_code),
						64'(result.status_code));
					bad |= field_differs("write_offset", 64'(want.write_offset),
						64'(result.write_offset));
					bad |= field_differs("missing_index", 64'(want.missing_index),
						64'(result.missing_index));
					bad |= field_differs("batch_end", 64'(want.batch_end),
						64'(result.batch_end));
					bad |= field_differs("run_last", 64'(want.run_last),
						64'(result.run_last));
					if (bad)
						fail_cnt++;
					beat_cnt++;
					if (want.result_kind == KIND_MISSING)
						entry_cnt++;
					if (want.result_kind == KIND_COMPLETE)
						done_cnt++;
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				track_packet(cmd);
		end
		failures      <= fail_cnt;
		outstanding   <= pending_beats.size();
		beats_checked <= beat_cnt;
		nack_entries  <= entry_cnt;
		completions   <= done_cnt;
	end

endmodule

@@ sim/tb.sv @@
// Testbench top of the receive tracker: clock, reset, packet stimulus, watchdog and verdict.
module tb;
	import srrt_pkg::*;

	// Longest quiet stretch allowed: the map clearing pass after reset and a full
	// circular scan of 4096 chunks both fit many times over.
	localparam int unsigned IDLE_LIMIT    = 50000;
	// Extra cycles after the last expected beat, well past the header latency.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned RANDOM_PHASES = 4;
	localparam int unsigned PHASE_ITEMS   = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       cmd;
	logic        result_valid;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned beats_checked;
	int unsigned nack_entries;
	int unsigned completions;

	// Stimulus bookkeeping. The current register values shape the random packets
	// so that most chunk headers pass the length and range checks.
	int unsigned packets_sent;
	int unsigned settings_used;
	int unsigned cur_frame;
	int unsigned cur_tot;
	bit          gappy;
	int unsigned burst_left;

	always #6 clk = ~clk;

	selective_repeat_receive_tracker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	receive_tracker_checker tracker_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.result_valid  (result_valid),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.nack_entries  (nack_entries),
		.completions   (completions)
	);

	function automatic item_t pkt(input logic [1:0] op, input logic [15:0] plen,
		input logic [31:0] seq, input logic [31:0] dlen);
		item_t it;
		it.opcode          = op;
		it.packet_length   = plen;
		it.sequence_number = seq;
		it.payload_length  = dlen;
		return it;
	endfunction

	// Chunk index 0 is kept unreceived until the closing phase, so no check request
	// can finish the transfer early; once finished, all packets but check requests are ignored.
	function automatic item_t random_packet();
		item_t       it;
		int unsigned pick;
		int unsigned dmax;
		it   = pkt(OP_CHUNK, 16'd0, 32'd0, 32'd0);
		pick = $urandom_range(0, 99);
		dmax = (cur_frame > 65535 - HEADER_BYTES) ? 65535 - HEADER_BYTES : cur_frame;
		if (pick < 55) begin
			// Well-formed chunk header with random content; duplicates come naturally.
			it.payload_length  = $urandom_range(0, dmax);
			it.packet_length   = 16'($urandom_range(HEADER_BYTES + it.payload_length, 65535));
			it.sequence_number = $urandom_range(1, cur_tot - 1);
		end else if (pick < 75) begin
			it.opcode          = OP_CHECK;
			it.packet_length   = 16'($urandom_range(MIN_PACKET_BYTES, 65535));
			it.sequence_number = $urandom;
			it.payload_length  = $urandom;
		end else if (pick < 80) begin
			// Runt datagram of any kind.
			it.opcode          = 2'($urandom_range(0, 3));
			it.packet_length   = 16'($urandom_range(0, MIN_PACKET_BYTES - 1));
			it.sequence_number = $urandom;
			it.payload_length  = $urandom;
		end else if (pick < 84) begin
			// Chunk too short to hold its header.
			it.packet_length   = 16'($urandom_range(MIN_PACKET_BYTES, HEADER_BYTES - 1));
			it.sequence_number = $urandom;
			it.payload_length  = $urandom;
		end else if (pick < 90) begin
			it.sequence_number = $urandom_range(0, cur_tot - 1);
			if ($urandom_range(0, 1)) begin
				// Payload larger than a frame.
				it.payload_length = cur_frame + $urandom_range(1, 1000);
				it.packet_length  = 16'($urandom_range(HEADER_BYTES, 65535));
			end else begin
				// Datagram shorter than header plus payload.
				it.payload_length = $urandom_range(1, dmax);
				it.packet_length  = 16'($urandom_range(HEADER_BYTES,
					HEADER_BYTES + it.payload_length - 1));
			end
		end else if (pick < 95) begin
			// Sequence number past the chunk count, either just past or far out.
			it.payload_length = $urandom_range(0, dmax);
			it.packet_length  = 16'($urandom_range(HEADER_BYTES + it.payload_length, 65535));
			if ($urandom_range(0, 1))
				it.sequence_number = cur_tot + $urandom_range(0, 7);
			else
				it.sequence_number = {1'b1, 31'($urandom)};
		end else begin
			it.opcode          = 2'($urandom_range(2, 3));
			it.packet_length   = 16'($urandom_range(MIN_PACKET_BYTES, 65535));
			it.sequence_number = $urandom;
			it.payload_length  = $urandom;
		end
		return it;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_setting(input logic [15:0] frame, input logic [15:0] total);
		write_reg(REG_FRAME_BYTES, frame);
		write_reg(REG_CHUNK_TOTAL, total);
		cur_frame = 32'(frame);
		cur_tot   = 32'(total[12:0]);
		if (cur_tot == 0)
			cur_tot = 1;
		else if (cur_tot > MAX_CHUNKS)
			cur_tot = MAX_CHUNKS;
		settings_used++;
	endtask

	// The sender works in bursts; in gappy phases start drops for a random gap between bursts.
	// Since the gap counts from acceptance, it lands on every stage of the work.
	task automatic pace();
		int unsigned gap;
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 8);
			if (gappy) begin
				gap = $urandom_range(1, 10);
				@(negedge clk);
				start = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Start stays high through busy; the packet goes in on the first edge with busy low.
	task automatic send_packet(input item_t it);
		@(negedge clk);
		start = 1'b1;
		cmd   = it;
		do @(posedge clk); while (busy !== 1'b0);
		packets_sent++;
		pace();
	endtask

	// Waits until every predicted beat has come out. The count is read at the falling
	// edge, after the checker has taken the edge's handshakes into account.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1 ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles, giving up", $time, IDLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		cmd           = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_FRAME_BYTES;
		cfg_data      = '0;
		packets_sent  = 0;
		settings_used = 0;
		cur_frame     = 32'(FRAME_BYTES_RST);
		cur_tot       = 32'(CHUNK_TOTAL_RST);
		gappy         = 1'b0;
		burst_left    = 1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// The registers are written while the map clearing pass keeps busy high.
		// Largest frame, and a chunk total above the map size that clamps to 4096.
		apply_setting(16'hFFFF, 16'h1FFF);

		// Directed packets: every rejection path, field extremes, and the largest
		// write offset. Chunk 0 is only ever rejected here.
		send_packet(pkt(OP_CHUNK, 16'd0, 32'd0, 32'd0));
		send_packet(pkt(OP_CHECK, 16'(MIN_PACKET_BYTES - 1), 32'd0, 32'd0));
		send_packet(pkt(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_packet(pkt(2'd2, 16'(MIN_PACKET_BYTES), 32'd5, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES - 1), 32'd3, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'hFFFF, 32'd3, 32'hFFFF_FFFF));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd3, 32'd1));
		send_packet(pkt(OP_CHUNK, 16'hFFFF, 32'd0, 32'hFFFF));
		send_packet(pkt(OP_CHUNK, 16'hFFFF, 32'd4096, 32'(65535 - HEADER_BYTES)));
		send_packet(pkt(OP_CHUNK, 16'hFFFF, 32'hFFFF_FFFF, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd4095, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd4095, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'hFFFF, 32'd1, 32'(65535 - HEADER_BYTES)));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES + 100), 32'd2, 32'd100));
		// A nearly empty map of 4096 chunks: ten full batches, the most beats per packet.
		send_packet(pkt(OP_CHECK, 16'(MIN_PACKET_BYTES), 32'd0, 32'd0));
		send_packet(pkt(OP_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		drain();

		// Random phases under different settings; the first runs without gaps. The
		// chunk count changes between them, so the kept scan pointer often lies
		// beyond the new count and wraps.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_setting(16'd1, 16'd2);
				1: apply_setting(16'($urandom_range(2, 2000)), 16'($urandom_range(3, 24)));
				2: apply_setting(16'hFFFF, 16'(MAX_CHUNKS));
				default: apply_setting(16'($urandom_range(1, 65535)),
					16'($urandom_range(25, 300)));
			endcase
			gappy      = (phase != 0);
			burst_left = 1;
			repeat (PHASE_ITEMS) send_packet(random_packet());
			drain();
		end

		// Closing phase: a chunk total of zero acts as one chunk. The last missing
		// chunk arrives, a check request finds none missing and the transfer completes;
		// everything after is ignored except check requests, which report completion again.
		apply_setting(16'd500, 16'd0);
		gappy = 1'b1;
		send_packet(pkt(OP_CHECK, 16'd64, 32'd0, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd1, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd0, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd0, 32'd0));
		send_packet(pkt(OP_CHECK, 16'd64, 32'd0, 32'd0));
		send_packet(pkt(OP_CHECK, 16'd64, 32'd7, 32'd9));
		send_packet(pkt(OP_CHUNK, 16'(HEADER_BYTES), 32'd0, 32'd0));
		send_packet(pkt(OP_CHUNK, 16'd0, 32'd0, 32'd0));
		send_packet(pkt(2'd2, 16'd100, 32'd0, 32'd0));
		drain();

		$display("Run covered %0d packets under %0d register settings, from one chunk to 4096.",
			packets_sent, settings_used);
		$display("It checked %0d result beats: %0d NACK entries and %0d completion reports.",
			beats_checked, nack_entries, completions);
		if (failures == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
